// File: design/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, constants and window helpers for the delimited packet
// deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

  // Longest delimiter the configuration may ask for, and largest packet.
  localparam int unsigned MAX_DELIM  = 8;
  localparam int unsigned MAX_PACKET = 4096;

  localparam int unsigned WinBytes  = 8;
  localparam int unsigned DelimLim  = (MAX_DELIM < WinBytes) ? MAX_DELIM : WinBytes;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_CFG_ERR  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_START_PAT = 3'd0,
    CFG_START_LEN = 3'd1,
    CFG_END_PAT   = 3'd2,
    CFG_END_LEN   = 3'd3,
    CFG_PKT_LEN   = 3'd4,
    CFG_BUF_CAP   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        packet_end;
    status_e     status;
    logic [12:0] payload_length;
  } res_t;

  typedef struct packed {
    logic [63:0] win;
    logic [3:0]  fill;
    logic        evicted;
    logic [7:0]  old;
  } push_t;

  // Mask covering the low n bytes of a window; eight or more covers all.
  function automatic logic [63:0] bytes_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < int'(WinBytes); i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Appends byte b to a window that holds up to n bytes, oldest in the low
  // byte. When the window is full the oldest byte drops out.
  function automatic push_t win_push(logic [63:0] w, logic [3:0] fill,
                                     logic [3:0] n, logic [7:0] b);
    push_t       r;
    logic [63:0] ws;
    logic [3:0]  f;
    r.evicted = (fill >= n);
    r.old     = w[7:0];
    if (r.evicted) begin
      ws = w >> 8;
      f  = n - 4'd1;
    end else begin
      ws = w;
      f  = fill;
    end
    for (int i = 0; i < int'(WinBytes); i++) begin
      if (4'(i) < f) begin
        r.win[8*i +: 8] = ws[8*i +: 8];
      end else if (4'(i) == f) begin
        r.win[8*i +: 8] = b;
      end else begin
        r.win[8*i +: 8] = 8'h00;
      end
    end
    r.fill = f + 4'd1;
    return r;
  endfunction

endpackage

// File: design/delimited_packet_deframer.sv
// ----------------------------------------------------------------------------
// delimited_packet_deframer
// Splits a received byte stream into packets framed by an optional start
// delimiter and either a fixed length or an end delimiter.
// ----------------------------------------------------------------------------
// Every accepted item (a received byte or a read timeout) produces exactly
// one result item, available in the cycle after it is accepted unless an
// earlier result is still waiting on a stalled consumer, and a new item can
// be accepted in every cycle while in_stall_o is low: the whole per-item
// update is a single pass of window compares over at most eight bytes and a
// few 13-bit count compares, ahead of the result register. A two-entry output
// stage (result register plus skid register) lets the block keep taking items
// while one result waits on a stalled consumer; in_stall_o rises only when
// both entries are occupied. While a start delimiter is configured, bytes are
// hunted through a sliding window and the matching bytes are consumed without
// releasing anything. Payload is then released either as exactly packet_length
// bytes, or up to a matched end delimiter whose bytes are kept in a delay
// window and never released. An overflow, a timeout or an invalid configuration
// closes the packet with a nonzero status, and the consumer is expected to drop
// that packet. A configuration write to a defined index abandons the current
// packet silently and rearms; writes must only be made while the block is idle.
module delimited_packet_deframer
  import dpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,

  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic [1:0]  status_o,
  output logic [12:0] payload_length_o
);

  // Configuration registers.
  logic [63:0] start_pat_q, end_pat_q;
  logic [3:0]  start_size_q, end_len_q;
  logic [12:0] pkt_len_q, buf_cap_q;

  // Framing state.
  logic        seek_q, seek_d;
  logic [63:0] start_win_q, start_win_d;
  logic [3:0]  start_fill_q, start_fill_d;
  logic [63:0] end_win_q, end_win_d;
  logic [3:0]  end_fill_q, end_fill_d;
  logic [12:0] byte_cnt_q, byte_cnt_d;

  // Output stage.
  res_t out_q, skid_q, res;
  logic out_vld_q, skid_vld_q;

  logic        accept, out_take;
  logic        cfg_hit;
  logic [3:0]  new_start_size;
  logic [12:0] cap, released, cnt_inc;
  logic        cfg_bad;
  logic        finish;
  push_t       sp, ep;

  assign accept   = in_valid_i && !skid_vld_q;
  assign out_take = out_vld_q && !res_stall_i;

  assign in_stall_o       = skid_vld_q;
  assign res_valid_o      = out_vld_q;
  assign out_valid_o      = out_q.out_valid;
  assign out_byte_o       = out_q.out_byte;
  assign packet_end_o     = out_q.packet_end;
  assign status_o         = out_q.status;
  assign payload_length_o = out_q.payload_length;

  // Effective capacity: buffer size, lowered to a nonzero packet length and
  // to the largest supported packet.
  always_comb begin
    cap = buf_cap_q;
    if (pkt_len_q != '0 && pkt_len_q < cap) begin
      cap = pkt_len_q;
    end
    if (32'(cap) > MAX_PACKET) begin
      cap = 13'(MAX_PACKET);
    end
  end

  always_comb begin
    cfg_bad = 1'b0;
    if (32'(start_size_q) > DelimLim || 32'(end_len_q) > DelimLim) begin
      cfg_bad = 1'b1;
    end else if (end_len_q == '0) begin
      cfg_bad = (pkt_len_q == '0) || (pkt_len_q > buf_cap_q) ||
                (32'(pkt_len_q) > MAX_PACKET);
    end else begin
      cfg_bad = (cap == '0);
    end
  end

  // Per-item update: one result and the next framing state.
  always_comb begin
    sp = win_push(start_win_q, start_fill_q, start_size_q, rx_byte_i);
    ep = win_push(end_win_q, end_fill_q, end_len_q, rx_byte_i);
    released = (byte_cnt_q >= 13'(end_fill_q)) ? byte_cnt_q - 13'(end_fill_q) : '0;
    cnt_inc  = byte_cnt_q + 13'd1;

    res          = '0;
    res.status   = ST_OK;
    finish       = 1'b0;
    seek_d       = seek_q;
    start_win_d  = start_win_q;
    start_fill_d = start_fill_q;
    end_win_d    = end_win_q;
    end_fill_d   = end_fill_q;
    byte_cnt_d   = byte_cnt_q;

    if (cfg_bad) begin
      finish             = 1'b1;
      res.status         = ST_CFG_ERR;
      res.payload_length = released;
    end else if (func_i) begin
      finish             = 1'b1;
      res.status         = ST_TIMEOUT;
      res.payload_length = released;
    end else if (seek_q && start_size_q != '0) begin
      start_win_d  = sp.win;
      start_fill_d = sp.fill;
      if (sp.fill == start_size_q &&
          ((sp.win ^ start_pat_q) & bytes_mask(start_size_q)) == '0) begin
        seek_d       = 1'b0;
        start_win_d  = '0;
        start_fill_d = '0;
      end
    end else if (end_len_q == '0) begin
      // Fixed length: every byte is payload.
      seek_d        = 1'b0;
      res.out_valid = 1'b1;
      res.out_byte  = rx_byte_i;
      byte_cnt_d    = cnt_inc;
      if (cnt_inc >= pkt_len_q) begin
        finish             = 1'b1;
        res.payload_length = cnt_inc;
      end
    end else begin
      seek_d = 1'b0;
      if (byte_cnt_q >= cap) begin
        finish             = 1'b1;
        res.status         = ST_OVERFLOW;
        res.payload_length = released;
      end else begin
        byte_cnt_d = cnt_inc;
        end_win_d  = ep.win;
        end_fill_d = ep.fill;
        if (ep.evicted) begin
          res.out_valid = 1'b1;
          res.out_byte  = ep.old;
        end
        if (ep.fill == end_len_q &&
            ((ep.win ^ end_pat_q) & bytes_mask(end_len_q)) == '0) begin
          finish             = 1'b1;
          res.payload_length = cnt_inc - 13'(end_len_q);
        end
      end
    end

    if (finish) begin
      res.packet_end = 1'b1;
      seek_d         = (start_size_q != '0);
      start_win_d    = '0;
      start_fill_d   = '0;
      end_win_d      = '0;
      end_fill_d     = '0;
      byte_cnt_d     = '0;
    end
  end

  // Configuration decode.
  always_comb begin
    cfg_hit        = 1'b0;
    new_start_size = start_size_q;
    unique case (cfg_idx_e'(cfg_idx_i))
      CFG_START_LEN: begin
        cfg_hit        = 1'b1;
        new_start_size = cfg_data_i[3:0];
      end
      CFG_START_PAT, CFG_END_PAT, CFG_END_LEN, CFG_PKT_LEN, CFG_BUF_CAP: begin
        cfg_hit = 1'b1;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
    cfg_hit = cfg_hit && cfg_we_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pat_q  <= '0;
      start_size_q <= '0;
      end_pat_q    <= '0;
      end_len_q    <= 4'd1;
      pkt_len_q    <= '0;
      buf_cap_q    <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_PAT: start_pat_q  <= cfg_data_i;
        CFG_START_LEN: start_size_q <= cfg_data_i[3:0];
        CFG_END_PAT:   end_pat_q    <= cfg_data_i;
        CFG_END_LEN:   end_len_q    <= cfg_data_i[3:0];
        CFG_PKT_LEN:   pkt_len_q    <= cfg_data_i[12:0];
        CFG_BUF_CAP:   buf_cap_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Framing state: a write to a defined register rearms, otherwise an item advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_q       <= 1'b0;
      start_win_q  <= '0;
      start_fill_q <= '0;
      end_win_q    <= '0;
      end_fill_q   <= '0;
      byte_cnt_q   <= '0;
    end else if (cfg_hit) begin
      seek_q       <= (new_start_size != '0);
      start_win_q  <= '0;
      start_fill_q <= '0;
      end_win_q    <= '0;
      end_fill_q   <= '0;
      byte_cnt_q   <= '0;
    end else if (accept) begin
      seek_q       <= seek_d;
      start_win_q  <= start_win_d;
      start_fill_q <= start_fill_d;
      end_win_q    <= end_win_d;
      end_fill_q   <= end_fill_d;
      byte_cnt_q   <= byte_cnt_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_vld_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

// File: dv/delimited_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// delimited_packet_deframer_tb
// Self-checking testbench for the delimited packet deframer. The block is fed
// received bytes and read timeouts under several framing setups. Every
// accepted item is run through a behavioral copy of the framing rules to get
// the result the block owes for it, and every result the block hands over is
// compared field by field against the oldest owed result.
// ----------------------------------------------------------------------------
module delimited_packet_deframer_tb
  import dpd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Item kinds carried on func_i.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // A register index past the last register; a write there must do nothing.
  localparam logic [2:0] UNUSED_IDX = 3'd7;

  // Cycles without any accepted item on either side before the run is called hung.
  localparam int unsigned QUIET_LIMIT = 2000;

  // Items per random phase; there are three phases with different idling.
  localparam int unsigned PHASE_ITEMS = 300;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the registers and the framing state,
  // works out the result owed for each accepted item and checks the results.
  // --------------------------------------------------------------------------
  class deframe_scoreboard;
    logic [63:0] start_pat, end_pat;
    logic [3:0]  start_size, end_len;
    logic [12:0] pkt_len, buf_cap;

    bit          hunting;
    logic [63:0] start_win, end_win;
    int unsigned start_fill, end_fill, taken;

    res_t        pending_results[$];
    int unsigned errors;

    function new();
      start_pat  = '0;
      start_size = '0;
      end_pat    = '0;
      end_len    = 4'd1;
      pkt_len    = '0;
      buf_cap    = 13'd4096;
      errors     = 0;
      rearm();
    endfunction

    // Every packet end and every register write start the framing over.
    function void rearm();
      hunting    = (start_size != 0);
      start_win  = '0;
      start_fill = 0;
      end_win    = '0;
      end_fill   = 0;
      taken      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        CFG_START_PAT: start_pat  = val;
        CFG_START_LEN: start_size = val[3:0];
        CFG_END_PAT:   end_pat    = val;
        CFG_END_LEN:   end_len    = val[3:0];
        CFG_PKT_LEN:   pkt_len    = val[12:0];
        CFG_BUF_CAP:   buf_cap    = val[12:0];
        default:       return;
      endcase
      rearm();
    endfunction

    // Largest packet including the end delimiter.
    function int unsigned cap_bytes();
      int unsigned c;
      c = 32'(buf_cap);
      if (pkt_len != 0 && 32'(pkt_len) < c) c = 32'(pkt_len);
      if (c > MAX_PACKET) c = MAX_PACKET;
      return c;
    endfunction

    function bit settings_bad();
      if (start_size > DelimLim || end_len > DelimLim) return 1'b1;
      if (end_len == 0) begin
        return (pkt_len == 0) || (pkt_len > buf_cap) || (pkt_len > MAX_PACKET);
      end
      return cap_bytes() == 0;
    endfunction

    function logic [63:0] low_bytes(int unsigned n);
      if (n == 0) return '0;
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Shifts byte b into a window of at most n bytes, oldest in the low byte.
    // Returns 1 when the oldest byte had to drop out, and hands it back.
    function bit shift_in(inout logic [63:0] w, inout int unsigned fill,
                          input int unsigned n, input logic [7:0] b,
                          output logic [7:0] old);
      bit dropped;
      dropped = 1'b0;
      old     = 8'h00;
      if (fill >= n) begin
        old     = w[7:0];
        w       = w >> 8;
        fill    = n - 1;
        dropped = 1'b1;
      end
      w = (w & low_bytes(fill)) | (64'(b) << (8 * fill));
      fill++;
      return dropped;
    endfunction

    function void close_packet(inout res_t r, input status_e st, input int unsigned len);
      r.packet_end     = 1'b1;
      r.status         = st;
      r.payload_length = 13'(len);
      rearm();
    endfunction

    // Works out the one result an accepted item causes and queues it.
    function void deframe_item(logic kind, logic [7:0] b);
      res_t        r;
      logic [7:0]  old;
      int unsigned released;
      r        = '0;
      released = (taken >= end_fill) ? taken - end_fill : 0;
      if (settings_bad()) begin
        close_packet(r, ST_CFG_ERR, released);
      end else if (kind == KIND_TIMEOUT) begin
        close_packet(r, ST_TIMEOUT, released);
      end else begin
        if (hunting && start_size == 0) hunting = 1'b0;
        if (hunting) begin
          void'(shift_in(start_win, start_fill, 32'(start_size), b, old));
          if (start_fill == start_size &&
              ((start_win ^ start_pat) & low_bytes(32'(start_size))) == '0) begin
            hunting    = 1'b0;
            start_win  = '0;
            start_fill = 0;
          end
        end else if (end_len == 0) begin
          r.out_valid = 1'b1;
          r.out_byte  = b;
          taken++;
          if (taken >= pkt_len) close_packet(r, ST_OK, taken);
        end else if (taken >= cap_bytes()) begin
          close_packet(r, ST_OVERFLOW, released);
        end else begin
          taken++;
          if (shift_in(end_win, end_fill, 32'(end_len), b, old)) begin
            r.out_valid = 1'b1;
            r.out_byte  = old;
          end
          if (end_fill == end_len &&
              ((end_win ^ end_pat) & low_bytes(32'(end_len))) == '0) begin
            close_packet(r, ST_OK, taken - 32'(end_len));
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 200) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 200) begin
          $display("%0t: result with none pending, expected nothing actual %h", $time, got);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.out_valid !== want.out_valid) begin
        flag("out_valid", 64'(want.out_valid), 64'(got.out_valid));
      end
      if (got.out_byte !== want.out_byte) begin
        flag("out_byte", 64'(want.out_byte), 64'(got.out_byte));
      end
      if (got.packet_end !== want.packet_end) begin
        flag("packet_end", 64'(want.packet_end), 64'(got.packet_end));
      end
      if (got.status !== want.status) begin
        flag("status", 64'(want.status), 64'(got.status));
      end
      if (got.payload_length !== want.payload_length) begin
        flag("payload_length", 64'(want.payload_length), 64'(got.payload_length));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs. Every input holds a known value from time
  // zero; reset is asserted from the start and released once.
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        func_i      = KIND_BYTE;
  logic [7:0]  rx_byte_i   = '0;
  logic        res_stall_i = 1'b0;

  logic        in_stall_o;
  logic        res_valid_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        packet_end_o;
  logic [1:0]  status_o;
  logic [12:0] payload_length_o;

  deframe_scoreboard scb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;

  always #6 clk_i = ~clk_i;

  delimited_packet_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .packet_end_o     (packet_end_o),
    .status_o         (status_o),
    .payload_length_o (payload_length_o)
  );

  // The consumer stalls at random, at the rate the current phase asks for.
  always @(posedge clk_i) begin
    res_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result monitor and watchdog. Values are sampled as they stood just before
  // the edge, so the order of events inside the time step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i) begin
        scb.check_result(res_t'({out_valid_o, out_byte_o, packet_end_o, status_o,
                                 payload_length_o}));
      end
      if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL delimited_packet_deframer");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. They always start right after a rising edge and drive with
  // nonblocking assignments, so each input changes once per edge at most.
  // --------------------------------------------------------------------------

  // Offers one item, idling first at the phase's rate. Once valid is raised
  // the item is held until the block takes it; the scoreboard learns of it at
  // the accepting edge.
  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= kind;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    scb.deframe_item(kind, b);
    items_sent++;
  endtask

  // Stops offering items until every owed result has been handed over, then
  // idles further so the output stage is surely empty.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (scb.pending_results.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // One register write. The enable drops afterwards so that back-to-back
  // writes never drive the enable twice in one step.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    scb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Half the time, fills the bits above a register's width with noise; the
  // block is meant to ignore them.
  function automatic logic [63:0] with_junk(logic [63:0] v, int unsigned w);
    if ($urandom_range(1) == 0) return v;
    return v | ({$urandom(), $urandom()} << w);
  endfunction

  task automatic apply_settings(input logic [63:0] sp, input logic [3:0] sl,
                                input logic [63:0] ep, input logic [3:0] el,
                                input logic [12:0] pl, input logic [12:0] bc);
    wait_drained();
    write_reg(CFG_START_PAT, sp);
    write_reg(CFG_START_LEN, with_junk(64'(sl), 4));
    write_reg(CFG_END_PAT, ep);
    write_reg(CFG_END_LEN, with_junk(64'(el), 4));
    write_reg(CFG_PKT_LEN, with_junk(64'(pl), 13));
    write_reg(CFG_BUF_CAP, with_junk(64'(bc), 13));
  endtask

  // A delimiter is either random bytes or one byte repeated; the repeated
  // form makes overlapping partial matches likely.
  function automatic logic [63:0] random_delim();
    if ($urandom_range(4) == 0) return {8{8'($urandom)}};
    return {$urandom(), $urandom()};
  endfunction

  // Picks a framing setup. Most are valid and small so packets close often;
  // a few use the largest sizes, and some are invalid on purpose.
  task automatic pick_settings();
    logic [3:0]  sl, el;
    logic [12:0] pl, bc;
    int unsigned roll;
    roll = $urandom_range(99);
    sl   = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
    el   = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
    if (el == 0) begin
      pl = 13'($urandom_range(1, 24));
      bc = pl + 13'($urandom_range(0, 40));
    end else begin
      pl = ($urandom_range(1) == 0) ? 13'd0 : 13'($urandom_range(1, 30));
      bc = 13'($urandom_range(1, 40));
    end
    if (roll < 8) begin
      bc = ($urandom_range(1) == 0) ? 13'd4096 : 13'd8191;
    end else if (roll < 16) begin
      case ($urandom_range(5))
        0: sl = 4'($urandom_range(9, 15));
        1: el = 4'($urandom_range(9, 15));
        2: begin
          el = 4'd0;
          pl = 13'd0;
        end
        3: begin
          el = 4'd0;
          pl = bc + 13'd1;
        end
        4: begin
          el = 4'd0;
          pl = 13'($urandom_range(4097, 8191));
          bc = 13'd8191;
        end
        default: begin
          el = 4'($urandom_range(1, 8));
          pl = 13'd0;
          bc = 13'd0;
        end
      endcase
    end
    apply_settings(random_delim(), sl, random_delim(), el, pl, bc);
  endtask

  // Sends one frame shaped for the current setup: optional line noise, the
  // start delimiter, a payload and the end delimiter. Delimiter bytes are
  // now and then corrupted, and timeouts, overlong payloads and idle-time
  // register writes break some frames on purpose.
  task automatic send_frame();
    logic [7:0]  b;
    int unsigned body, cap, room;
    if (scb.settings_bad()) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(($urandom_range(9) == 0) ? KIND_TIMEOUT : KIND_BYTE, 8'($urandom));
      end
      return;
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom));
    end
    for (int i = 0; i < scb.start_size; i++) begin
      b = scb.start_pat[8*i +: 8];
      if ($urandom_range(19) == 0) b ^= 8'(1 << $urandom_range(7));
      send_item(KIND_BYTE, b);
    end
    if (scb.end_len == 0) begin
      body = (scb.pkt_len > 40) ? 40 : 32'(scb.pkt_len);
    end else begin
      cap  = scb.cap_bytes();
      room = (cap > scb.end_len) ? cap - 32'(scb.end_len) : 0;
      body = $urandom_range(0, (room < 30) ? room : 30);
      if (cap < 48 && $urandom_range(9) == 0) body = cap + 1;
    end
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(59) == 0) send_item(KIND_TIMEOUT, 8'($urandom));
      else send_item(KIND_BYTE, 8'($urandom));
      if ($urandom_range(149) == 0) begin
        // With the block idle mid-packet: a rewrite with the same value must
        // drop the packet, a write past the last register must not.
        wait_drained();
        if ($urandom_range(1) == 0) write_reg(CFG_END_PAT, scb.end_pat);
        else write_reg(UNUSED_IDX, {$urandom(), $urandom()});
      end
    end
    for (int i = 0; i < scb.end_len; i++) begin
      b = scb.end_pat[8*i +: 8];
      if ($urandom_range(19) == 0) b ^= 8'(1 << $urandom_range(7));
      send_item(KIND_BYTE, b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned goal;
    send_idle_pct = 32;
    recv_idle_pct = 69;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setup: end mode with a one-byte zero delimiter. Two payload
    // bytes then the delimiter, a timeout on an empty packet, and a timeout
    // while a byte is still held back in the delay window.
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, 8'h80);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_TIMEOUT, 8'h5A);
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_TIMEOUT, 8'hA5);

    // Start hunt with a two-byte delimiter and a cap of three bytes: a
    // timeout during the hunt, then the start, then overflow on byte four.
    apply_settings(64'h0123_4567_89AB_CDEF, 4'd2, 64'hFFFF_FFFF_FFFF_0D0A, 4'd2,
                   13'd0, 13'd3);
    send_item(KIND_TIMEOUT, 8'h00);
    send_item(KIND_BYTE, 8'hEF);
    send_item(KIND_BYTE, 8'hCD);
    send_item(KIND_BYTE, 8'h11);
    send_item(KIND_BYTE, 8'h22);
    send_item(KIND_BYTE, 8'h33);
    send_item(KIND_BYTE, 8'h44);

    // Fixed length of two. A write past the last register in the middle of
    // the packet must leave it open, so the second byte still closes it.
    apply_settings(64'h0, 4'd0, 64'h0, 4'd0, 13'd2, 13'd2);
    send_item(KIND_BYTE, 8'h00);
    wait_drained();
    write_reg(UNUSED_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_BYTE, 8'hFF);

    // Invalid setups: every item closes a packet with a configuration error,
    // even a timeout.
    apply_settings(64'h0, 4'd9, 64'h0, 4'd1, 13'd0, 13'd4096);
    send_item(KIND_BYTE, 8'h3C);
    apply_settings(64'h0, 4'd0, 64'h0, 4'd0, 13'd0, 13'd4096);
    send_item(KIND_BYTE, 8'hC3);
    apply_settings(64'h0, 4'd0, 64'h0, 4'd3, 13'd0, 13'd0);
    send_item(KIND_TIMEOUT, 8'h96);
    apply_settings(64'h0, 4'd0, 64'h0, 4'd0, 13'd4097, 13'd8191);
    send_item(KIND_BYTE, 8'h7E);
    apply_settings(64'h0, 4'd0, 64'h0, 4'd0, 13'd5, 13'd4);
    send_item(KIND_BYTE, 8'h81);

    // Longest delimiters and the largest sizes.
    apply_settings(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd8, 13'd4096, 13'd8191);
    send_item(KIND_BYTE, 8'hFF);

    // Random phases: the consumer idles more than the sender, then the other
    // way round, then neither idles.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        pick_settings();
        repeat ($urandom_range(3, 8)) send_frame();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (scb.errors == 0 && scb.pending_results.size() == 0) begin
      $display("PASS delimited_packet_deframer");
    end else begin
      $display("FAIL delimited_packet_deframer");
    end
    $finish;
  end

endmodule
